### sv/nlf_pkg.sv
// ----------------------------------------------------------------------------
// nlf_pkg
// Shared types and constants of the newline-delimited line framer.
// ----------------------------------------------------------------------------
package nlf_pkg;

  localparam logic [7:0] LF_BYTE = 8'h0A;
  localparam logic [7:0] CR_BYTE = 8'h0D;

  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_END       = 2'd1;
  localparam logic [1:0] KIND_FINISH_OK = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
  localparam logic [1:0] ERR_EMPTY     = 2'd2;
  localparam logic [1:0] ERR_PARTIAL   = 2'd3;

  localparam logic       REQ_DATA   = 1'b0;
  localparam logic       REQ_FINISH = 1'b1;

  localparam logic [15:0] MAX_LINE_RESET = 16'd4096;
  localparam int unsigned NLF_QUEUE_DEPTH = 2;

  // One queue entry: the results caused by one input transaction.
  typedef struct packed {
    logic       pre_cr;
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] code;
  } nlf_cmd_t;

endpackage

### sv/nlf_front.sv
// ----------------------------------------------------------------------------
// nlf_front
// Accepts input transactions, tracks line state and classifies each item.
// ----------------------------------------------------------------------------
module nlf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       max_line_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output nlf_pkg::nlf_cmd_t cmd_o
);
  import nlf_pkg::*;

  logic [1:0]  sticky_q, sticky_d;
  logic [15:0] count_q, count_d;
  logic        cr_q, cr_d;
  logic        accept;
  logic        emit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && emit;

  always_comb begin
    sticky_d = sticky_q;
    count_d  = count_q;
    cr_d     = cr_q;
    emit     = 1'b1;
    cmd_o    = '{pre_cr: 1'b0, kind: KIND_BYTE, data: 8'h00, code: ERR_NONE};
    if (sticky_q != ERR_NONE) begin
      cmd_o.kind = KIND_ERROR;
      cmd_o.code = sticky_q;
    end else if (req_type_i == REQ_FINISH) begin
      if (count_q != '0) begin
        sticky_d   = ERR_PARTIAL;
        cmd_o.kind = KIND_ERROR;
        cmd_o.code = ERR_PARTIAL;
      end else begin
        cmd_o.kind = KIND_FINISH_OK;
      end
    end else if (data_byte_i == LF_BYTE) begin
      count_d = '0;
      cr_d    = 1'b0;
      if (count_q == '0 || (count_q == 16'd1 && cr_q)) begin
        sticky_d   = ERR_EMPTY;
        cmd_o.kind = KIND_ERROR;
        cmd_o.code = ERR_EMPTY;
      end else begin
        cmd_o.kind = KIND_END;
      end
    end else if (count_q >= max_line_i) begin
      sticky_d   = ERR_TOO_LARGE;
      cmd_o.kind = KIND_ERROR;
      cmd_o.code = ERR_TOO_LARGE;
    end else begin
      count_d = count_q + 16'd1;
      if (cr_q) begin
        if (data_byte_i == CR_BYTE) begin
          cmd_o.data = CR_BYTE;
        end else begin
          cmd_o.pre_cr = 1'b1;
          cmd_o.data   = data_byte_i;
          cr_d         = 1'b0;
        end
      end else if (data_byte_i == CR_BYTE) begin
        cr_d = 1'b1;
        emit = 1'b0;
      end else begin
        cmd_o.data = data_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_q <= ERR_NONE;
      count_q  <= '0;
      cr_q     <= 1'b0;
    end else if (accept) begin
      sticky_q <= sticky_d;
      count_q  <= count_d;
      cr_q     <= cr_d;
    end
  end

endmodule

### sv/nlf_queue.sv
// ----------------------------------------------------------------------------
// nlf_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module nlf_queue #(
  parameter int unsigned Depth = nlf_pkg::NLF_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nlf_pkg::nlf_cmd_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output nlf_pkg::nlf_cmd_t head_o
);
  import nlf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  nlf_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### sv/nlf_back.sv
// ----------------------------------------------------------------------------
// nlf_back
// Expands queued items into result transactions held in an output register.
// ----------------------------------------------------------------------------
module nlf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  nlf_pkg::nlf_cmd_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        out_byte_o,
  output logic [1:0]        error_code_o,
  output logic              last_o
);
  import nlf_pkg::*;

  logic       valid_q;
  logic       cr_done_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic [1:0] code_q;
  logic       last_q;
  logic       load;
  logic       send_cr;

  assign load    = !empty_i && (!valid_q || out_ready_i);
  assign send_cr = head_i.pre_cr && !cr_done_q;
  assign pop_o   = load && !send_cr;

  assign out_valid_o  = valid_q;
  assign kind_o       = kind_q;
  assign out_byte_o   = byte_q;
  assign error_code_o = code_q;
  assign last_o       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      cr_done_q <= 1'b0;
    end else if (load) begin
      valid_q   <= 1'b1;
      cr_done_q <= send_cr;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (send_cr) begin
        kind_q <= KIND_BYTE;
        byte_q <= CR_BYTE;
        code_q <= ERR_NONE;
        last_q <= 1'b0;
      end else begin
        kind_q <= head_i.kind;
        byte_q <= head_i.data;
        code_q <= head_i.code;
        last_q <= 1'b1;
      end
    end
  end

endmodule

### sv/ndjson_line_framer_unit.sv
// ----------------------------------------------------------------------------
// ndjson_line_framer_unit
// Splits a byte stream into LF-terminated lines, dropping a CR before LF.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tuser[0] req_type, tdata[7:0] data_byte
// m_axis    out        tuser[1:0] kind, tdata[7:0] out_byte,
//                      tdata[9:8] error_code, tlast last
// cfg       in         cfg_wdata[15:0] max_line_bytes
//
// One input transaction is taken per cycle while the queue is not full. A
// byte that releases a held CR gives two results, and the queue absorbs the
// extra one. Results pass through the queue and then the output register.
// Reset clears the line state, the error and the queue, and loads the limit
// with 4096. Either side may stall without losing anything.
// ----------------------------------------------------------------------------
module ndjson_line_framer_unit #(
  parameter int unsigned QueueDepth = nlf_pkg::NLF_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [9:8] error_code
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_wdata      // [15:0] max_line_bytes
);
  import nlf_pkg::*;

  logic [15:0] max_line_q;
  logic        q_full, q_empty, push, pop;
  nlf_cmd_t    cmd, head;
  logic [7:0]  out_byte;
  logic [1:0]  error_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= MAX_LINE_RESET;
    end else if (cfg_valid) begin
      max_line_q <= cfg_wdata;
    end
  end

  nlf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_line_i  (max_line_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  nlf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  nlf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .kind_o       (m_axis_tuser),
    .out_byte_o   (out_byte),
    .error_code_o (error_code),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, error_code, out_byte};

endmodule

### sv/nlf_checker.sv
// ----------------------------------------------------------------------------
// nlf_checker
// Port-level checks of the line framer result stream.
// ----------------------------------------------------------------------------
module nlf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import nlf_pkg::*;

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tlast)
    else $error("error result without tlast");

  a_code_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == KIND_ERROR) == (m_axis_tdata[9:8] != ERR_NONE)))
    else $error("error code does not match kind");

  a_byte_only_for_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tdata[7:0] == 8'h00)
    else $error("nonzero byte on a non-data result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind ndjson_line_framer_unit nlf_checker u_nlf_checker (.*);
